// ===== rtl/imgconv_pkg.sv =====
`timescale 1ns / 1ps
package imgconv_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;
  localparam int DEF_KMAX       = 5;

  localparam int CFG_W    = 11;
  localparam int CFG_IDX_W = 3;
  localparam int PIX_W    = 24;
  localparam int COEF_W   = 16;
  localparam int CIDX_W   = 5;
  localparam int IN_DATA_W = 48;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_COEF  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT  = 3'd1,
    REG_KERNEL_WIDTH  = 3'd2,
    REG_KERNEL_HEIGHT = 3'd3,
    REG_PAD_MODE      = 3'd4,
    REG_UNUSED5       = 3'd5,
    REG_UNUSED6       = 3'd6,
    REG_UNUSED7       = 3'd7
  } reg_idx_t;

  localparam logic PAD_ZERO      = 1'b0;
  localparam logic PAD_REPLICATE = 1'b1;

endpackage

// ===== rtl/imgconv_ram.sv =====
`timescale 1ns / 1ps
module imgconv_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 5120
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/image_convolution_2d_top.sv =====
`timescale 1ns / 1ps
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tdata pixel,coef index,coef value; tuser kind
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata filtered pixel; tlast frame end
// cfg       in   cfg_valid/cfg_ready            cfg_index register, cfg_data value
//
// one word at a time: a pixel or flush that emits holds the input from its accept to
// its result, set by one row store read and one multiply-accumulate per tap plus a
// pipeline drain; other words leave the input ready.
// after a frame width change the first emit within a frame adds a serial divide for x and y.
// rst is synchronous; the row store needs no clearing, the kernel resets to zero.
// a stalled output holds the block before it writes the next result.
module image_convolution_2d_top
  #(
  parameter int MAX_WIDTH  = imgconv_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = imgconv_pkg::DEF_MAX_HEIGHT,
  parameter int KMAX       = imgconv_pkg::DEF_KMAX
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // pixel_in[23:0], coef_index[28:24], coef_value[44:29], zero fill
  input  logic [imgconv_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [1:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pixel_out[23:0]
  output logic [imgconv_pkg::PIX_W-1:0]      m_axis_tdata,
  output logic                               m_axis_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [imgconv_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imgconv_pkg::CFG_W-1:0]      cfg_data
);

  import imgconv_pkg::*;

  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int CNT_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
  localparam int DEPTH = KMAX * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int KW    = $clog2(KMAX + 1);
  localparam int TAPS  = KMAX * KMAX;
  localparam int CI    = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int SW    = ((WW > HW) ? WW : HW) + 2;
  localparam int PW    = COEF_W + 9;
  localparam int ACC_W = PW + $clog2(TAPS + 1);
  localparam int DC_W  = $clog2(CNT_W + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIV   = 5'b00010,
    S_TAP   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  state_t state;

  logic [CFG_W-1:0] frame_width, frame_height;
  logic [2:0]       kernel_width, kernel_height;
  logic             pad_mode;

  logic signed [COEF_W-1:0] coef_tab [TAPS];

  logic [CNT_W-1:0] rec, emi;
  logic [AW-1:0]    wptr;
  logic [XW-1:0]    ex;
  logic [YW-1:0]    ey;
  logic             stale;

  // effective sizes
  logic [WW-1:0]    w;
  logic [HW-1:0]    h;
  logic [KW-1:0]    kw, kh, kcx, kcy;
  logic [CNT_W-1:0] n;
  logic [CNT_W:0]   lag;

  always_comb begin
    if (frame_width == '0) w = WW'(1);
    else if (32'(frame_width) > MAX_WIDTH) w = WW'(MAX_WIDTH);
    else w = WW'(frame_width);
    if (frame_height == '0) h = HW'(1);
    else if (32'(frame_height) > MAX_HEIGHT) h = HW'(MAX_HEIGHT);
    else h = HW'(frame_height);
    kw  = (32'(kernel_width) > KMAX) ? KW'(KMAX) : KW'(kernel_width);
    kh  = (32'(kernel_height) > KMAX) ? KW'(KMAX) : KW'(kernel_height);
    kcx = kw >> 1;
    kcy = kh >> 1;
    n   = CNT_W'(w) * CNT_W'(h);
    lag = (CNT_W + 1)'(kcy) * (CNT_W + 1)'(w) + (CNT_W + 1)'(kcx);
  end

  // input word fields
  kind_t               kind;
  logic [PIX_W-1:0]    in_pix;
  logic [CIDX_W-1:0]   in_cidx;
  logic [COEF_W-1:0]   in_coef;
  assign kind    = kind_t'(s_axis_tuser);
  assign in_pix  = s_axis_tdata[23:0];
  assign in_cidx = s_axis_tdata[28:24];
  assign in_coef = s_axis_tdata[44:29];

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  // counters as seen by the incoming word
  logic             wrap_now;
  logic [CNT_W-1:0] rec_eff, emi_eff;
  logic [AW-1:0]    wptr_eff;
  logic [AW-1:0]    wptr_inc;
  logic             pix_take, pix_emit, flush_emit;

  always_comb begin
    wrap_now   = (emi >= n);
    rec_eff    = wrap_now ? '0 : rec;
    emi_eff    = wrap_now ? '0 : emi;
    wptr_eff   = wrap_now ? '0 : wptr;
    wptr_inc   = (32'(wptr_eff) == DEPTH - 1) ? '0 : wptr_eff + AW'(1);
    pix_take   = (kind == KIND_PIXEL) && (rec_eff < n);
    pix_emit   = pix_take &&
                 ((CNT_W + 1)'(emi_eff) + lag < (CNT_W + 1)'(rec_eff) + (CNT_W + 1)'(1));
    flush_emit = (kind == KIND_FLUSH) && (rec_eff >= n) && (emi_eff < n);
  end

  logic accept;
  assign accept = s_axis_tvalid && s_axis_tready;

  // row store
  logic [AW-1:0]    raddr;
  logic [PIX_W-1:0] rdata;

  imgconv_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_row_store (
    .clk   (clk),
    .we    (accept && pix_take),
    .waddr (wptr_eff),
    .wdata (in_pix),
    .raddr (raddr),
    .rdata (rdata)
  );

  // divider for x, y after a width change
  logic [CNT_W-1:0] dq;
  logic [WW:0]      drem;
  logic [DC_W-1:0]  dcnt;
  logic [WW:0]      rem_t;
  logic             qbit;

  always_comb begin
    rem_t = {drem[WW-1:0], dq[CNT_W-1]};
    qbit  = (rem_t >= (WW + 1)'(w));
  end

  // tap issue
  logic [KW-1:0]          tkx, tky;
  logic signed [SW-1:0]   ix, iy;
  logic                   outside;
  logic [XW-1:0]          cx;
  logic [YW-1:0]          cy;
  logic [CI-1:0]          tidx;
  logic                   last_tap;

  always_comb begin
    ix = $signed(SW'(ex)) + $signed(SW'(tkx)) - $signed(SW'(kcx));
    iy = $signed(SW'(ey)) + $signed(SW'(tky)) - $signed(SW'(kcy));
    outside = (ix < 0) || (ix >= $signed(SW'(w))) || (iy < 0) || (iy >= $signed(SW'(h)));
    if (ix < 0) cx = '0;
    else if (ix >= $signed(SW'(w))) cx = XW'(w - WW'(1));
    else cx = XW'(ix);
    if (iy < 0) cy = '0;
    else if (iy >= $signed(SW'(h))) cy = YW'(h - HW'(1));
    else cy = YW'(iy);
    tidx     = CI'(tky * KMAX) + CI'(tkx);
    last_tap = (tkx == kw - KW'(1)) && (tky == kh - KW'(1));
  end

  // tap pipeline
  logic                     p1_v, p1_use;
  logic [XW-1:0]            p1_ix;
  logic [YW-1:0]            p1_iy;
  logic signed [COEF_W-1:0] p1_coef;
  logic                     p2_v, p2_use;
  logic [CNT_W-1:0]         p2_s;
  logic signed [COEF_W-1:0] p2_coef;
  logic                     p3_v, p3_use;
  logic signed [COEF_W-1:0] p3_coef;
  logic                     p4_v, p4_use;
  logic signed [PW-1:0]     p4_prod [3];
  logic signed [ACC_W-1:0]  acc [3];

  logic [CNT_W-1:0] gap;
  logic [AW-1:0]    gap_a;

  always_comb begin
    gap   = rec - p2_s;
    gap_a = AW'(gap);
    if (wptr >= gap_a) raddr = wptr - gap_a;
    else raddr = AW'((AW + 1)'(wptr) + (AW + 1)'(DEPTH) - (AW + 1)'(gap_a));
  end

  // round half up and clamp
  logic signed [ACC_W-1:0] rv [3];
  logic [7:0]              chan [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rv[c] = acc[c] + ACC_W'(2048);
      if (rv[c] < 0) chan[c] = 8'd0;
      else if ((rv[c] >>> 12) > ACC_W'(255)) chan[c] = 8'd255;
      else chan[c] = 8'(rv[c] >>> 12);
    end
  end

  logic out_free;
  assign out_free = !m_axis_tvalid || m_axis_tready;

  logic [CNT_W-1:0] emi_next;
  assign emi_next = emi + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frame_width   <= CFG_W'(1024);
      frame_height  <= CFG_W'(1024);
      kernel_width  <= 3'd3;
      kernel_height <= 3'd3;
      pad_mode      <= PAD_ZERO;
      for (int i = 0; i < TAPS; i++) coef_tab[i] <= '0;
      rec           <= '0;
      emi           <= '0;
      wptr          <= '0;
      ex            <= '0;
      ey            <= '0;
      stale         <= 1'b0;
      m_axis_tvalid <= 1'b0;
      p1_v          <= 1'b0;
      p2_v          <= 1'b0;
      p3_v          <= 1'b0;
      p4_v          <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_FRAME_WIDTH: begin
            frame_width <= cfg_data;
            stale       <= 1'b1;
          end
          REG_FRAME_HEIGHT:  frame_height  <= cfg_data;
          REG_KERNEL_WIDTH:  kernel_width  <= cfg_data[2:0];
          REG_KERNEL_HEIGHT: kernel_height <= cfg_data[2:0];
          REG_PAD_MODE:      pad_mode      <= cfg_data[0];
          default: ;
        endcase
      end

      if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;

      // pipeline advance
      p1_v <= 1'b0;
      p2_v <= p1_v;
      p3_v <= p2_v;
      p4_v <= p3_v;

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (wrap_now) begin
              ex <= '0;
              ey <= '0;
              if (!(cfg_valid && reg_idx_t'(cfg_index) == REG_FRAME_WIDTH)) stale <= 1'b0;
            end
            rec  <= rec_eff;
            emi  <= emi_eff;
            wptr <= wptr_eff;
            if (pix_take) begin
              rec  <= rec_eff + CNT_W'(1);
              wptr <= wptr_inc;
            end
            if ((kind == KIND_COEF) && (rec_eff == '0) && (emi_eff == '0) &&
                (32'(in_cidx) < TAPS)) begin
              coef_tab[CI'(in_cidx)] <= $signed(in_coef);
            end
            if (pix_emit || flush_emit) begin
              tkx <= '0;
              tky <= '0;
              for (int c = 0; c < 3; c++) acc[c] <= '0;
              dq   <= emi_eff;
              drem <= '0;
              dcnt <= DC_W'(CNT_W);
              if (stale && !wrap_now) state <= S_DIV;
              else if (kw == '0 || kh == '0) state <= S_DRAIN;
              else state <= S_TAP;
            end
          end
        end
        S_DIV: begin
          if (dcnt == '0) begin
            ex    <= XW'(drem);
            ey    <= YW'(dq);
            stale <= 1'b0;
            if (kw == '0 || kh == '0) state <= S_DRAIN;
            else state <= S_TAP;
          end else begin
            drem <= qbit ? rem_t - (WW + 1)'(w) : rem_t;
            dq   <= {dq[CNT_W-2:0], qbit};
            dcnt <= dcnt - DC_W'(1);
          end
        end
        S_TAP: begin
          p1_v    <= 1'b1;
          p1_use  <= !outside || (pad_mode == PAD_REPLICATE);
          p1_ix   <= cx;
          p1_iy   <= cy;
          p1_coef <= coef_tab[tidx];
          if (last_tap) begin
            state <= S_DRAIN;
          end else if (tkx == kw - KW'(1)) begin
            tkx <= '0;
            tky <= tky + KW'(1);
          end else begin
            tkx <= tkx + KW'(1);
          end
        end
        S_DRAIN: begin
          if (!p1_v && !p2_v && !p3_v && !p4_v) state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {chan[2], chan[1], chan[0]};
            m_axis_tlast  <= (emi_next == n);
            state         <= S_IDLE;
            if (emi_next >= n) begin
              emi  <= '0;
              rec  <= '0;
              wptr <= '0;
              ex   <= '0;
              ey   <= '0;
            end else begin
              emi <= emi_next;
              if (32'(ex) + 1 == 32'(w)) begin
                ex <= '0;
                ey <= ey + YW'(1);
              end else begin
                ex <= ex + XW'(1);
              end
            end
          end
        end
        default: state <= S_IDLE;
      endcase

      // stage 2: raster index of the sample
      p2_use  <= p1_use;
      p2_coef <= p1_coef;
      p2_s    <= CNT_W'(p1_iy) * CNT_W'(w) + CNT_W'(p1_ix);
      // stage 3: store read under way
      p3_use  <= p2_use;
      p3_coef <= p2_coef;
      // stage 4: channel products
      p4_use  <= p3_use;
      for (int c = 0; c < 3; c++) begin
        p4_prod[c] <= PW'(p3_coef) * PW'($signed({1'b0, rdata[8*c +: 8]}));
      end
      // stage 5: accumulate
      if (p4_v && p4_use) begin
        for (int c = 0; c < 3; c++) acc[c] <= acc[c] + ACC_W'(p4_prod[c]);
      end
    end
  end

endmodule
